/* sv/rcba_pkg.sv */
// ----------------------------------------------------------------------------
// rcba_pkg
// Shared types and codes for the reference-counted block allocator.
// ----------------------------------------------------------------------------
package rcba_pkg;

   localparam int IdW   = 32;
   localparam int SizeW = 25;
   localparam int RefW  = 16;
   localparam int OpW   = 3;
   localparam int StW   = 3;

   localparam logic [SizeW-1:0] PoolReset = 25'd10485760;
   localparam logic [SizeW-1:0] SizeMax   = {SizeW{1'b1}};
   localparam logic signed [RefW-1:0] RefMax = 16'sh7FFF;
   localparam logic signed [RefW-1:0] RefMin = -16'sh8000;

   localparam logic [OpW-1:0] OP_CREATE   = 3'd0;
   localparam logic [OpW-1:0] OP_SET      = 3'd1;
   localparam logic [OpW-1:0] OP_GET      = 3'd2;
   localparam logic [OpW-1:0] OP_INCREASE = 3'd3;
   localparam logic [OpW-1:0] OP_DECREASE = 3'd4;
   localparam logic [OpW-1:0] OP_COLLECT  = 3'd5;
   localparam logic [OpW-1:0] OP_COMPACT  = 3'd6;

   localparam logic [StW-1:0] ST_OK        = 3'd0;
   localparam logic [StW-1:0] ST_NO_MEMORY = 3'd1;
   localparam logic [StW-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [StW-1:0] ST_TOO_LONG  = 3'd3;
   localparam logic [StW-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [IdW-1:0]          id;
      logic [SizeW-1:0]        offset;
      logic [SizeW-1:0]        size;
      logic signed [RefW-1:0]  refs;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch request word, clear scan state
      logic rd;       // read table entry at scan index
      logic eval;     // process read entry, advance scan
      logic finish;   // commit and load result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_scan;
      logic scan_done;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

/* sv/rcba_ctrl.sv */
// ----------------------------------------------------------------------------
// rcba_ctrl
// Sequencer: accept, table walk, commit.
// ----------------------------------------------------------------------------
module rcba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rcba_pkg::stat_type stat,
   output rcba_pkg::cmd_type  cmd
);
   import rcba_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FINISH} state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_tready = ready_ff;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!stat.needs_scan || stat.scan_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.hit ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               ready_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

/* sv/rcba_dp.sv */
// ----------------------------------------------------------------------------
// rcba_dp
// Datapath: block table memory, cursor, id counter, scan state, result word.
// ----------------------------------------------------------------------------
module rcba_dp #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rcba_pkg::OpW-1:0]   in_op,
   input  logic [rcba_pkg::IdW-1:0]   in_id,
   input  logic [rcba_pkg::SizeW-1:0] in_req,
   input  logic [rcba_pkg::SizeW-1:0] in_vlen,
   input  logic                       csr_valid,
   input  logic [rcba_pkg::SizeW-1:0] csr_data,
   input  rcba_pkg::cmd_type          cmd,
   output rcba_pkg::stat_type         stat,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rcba_pkg::StW-1:0]   out_status,
   output logic [rcba_pkg::IdW-1:0]   out_id,
   output logic [rcba_pkg::SizeW-1:0] out_offset,
   output logic [rcba_pkg::SizeW-1:0] out_length,
   output logic signed [rcba_pkg::RefW-1:0] out_refs,
   output logic                       out_changed
);
   import rcba_pkg::*;

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   entry_type mem [MAX_BLOCKS];
   entry_type rdata_ff;

   logic [OpW-1:0]   op_ff;
   logic [IdW-1:0]   id_ff;
   logic [SizeW-1:0] req_ff, vlen_ff;
   logic [CW-1:0]    idx_ff, w_ff, count_ff;
   logic [SizeW-1:0] pos_ff, cursor_ff, pool_ff;
   logic [IdW-1:0]   next_id_ff;
   logic             chg_ff, found_ff;
   logic [AW-1:0]    fidx_ff;
   entry_type        fent_ff;

   logic             out_valid_ff;
   logic [StW-1:0]   st_ff;
   logic [IdW-1:0]   oid_ff;
   logic [SizeW-1:0] ooff_ff, olen_ff;
   logic signed [RefW-1:0] oref_ff;
   logic             ochg_ff;

   logic             id_op, live, match;
   logic [SizeW:0]   pos_sum, alloc_sum;
   logic [SizeW-1:0] pos_sat;
   logic signed [RefW-1:0] new_refs;
   logic             oom, full;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;

   assign id_op = (op_ff == OP_SET) || (op_ff == OP_GET) ||
                  (op_ff == OP_INCREASE) || (op_ff == OP_DECREASE);
   assign live  = rdata_ff.refs > 0;
   assign match = rdata_ff.id == id_ff;

   assign pos_sum   = {1'b0, pos_ff} + {1'b0, rdata_ff.size};
   assign pos_sat   = pos_sum[SizeW] ? SizeMax : pos_sum[SizeW-1:0];
   assign alloc_sum = {1'b0, cursor_ff} + {1'b0, req_ff};
   assign oom       = alloc_sum > {1'b0, pool_ff};
   assign full      = count_ff == CW'(MAX_BLOCKS);

   always_comb begin
      new_refs = fent_ff.refs;
      if (op_ff == OP_INCREASE && fent_ff.refs < RefMax) new_refs = fent_ff.refs + 16'sd1;
      if (op_ff == OP_DECREASE && fent_ff.refs > RefMin) new_refs = fent_ff.refs - 16'sd1;
   end

   assign stat.needs_scan = id_op || (op_ff == OP_COLLECT) || (op_ff == OP_COMPACT);
   assign stat.scan_done  = idx_ff == count_ff;
   assign stat.hit        = id_op && match;
   assign stat.out_free   = !out_valid_ff || out_ready;

   // single write port: eval (collect move, compact offset) or finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rdata_ff;
      if (cmd.eval && op_ff == OP_COLLECT && live) begin
         wr_en   = 1'b1;
         wr_addr = w_ff[AW-1:0];
      end
      if (cmd.eval && op_ff == OP_COMPACT && live && rdata_ff.offset != pos_ff) begin
         wr_en          = 1'b1;
         wr_data.offset = pos_ff;
      end
      if (cmd.finish && op_ff == OP_CREATE && !oom && !full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = '{id: next_id_ff, offset: cursor_ff, size: req_ff, refs: 16'sd1};
      end
      if (cmd.finish && id_op && found_ff &&
          (op_ff == OP_INCREASE || op_ff == OP_DECREASE)) begin
         wr_en        = 1'b1;
         wr_addr      = fidx_ff;
         wr_data      = fent_ff;
         wr_data.refs = new_refs;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd) rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   // request latch and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         w_ff   <= '0;
      end else if (cmd.load) begin
         op_ff    <= in_op;
         id_ff    <= in_id;
         req_ff   <= in_req;
         vlen_ff  <= in_vlen;
         idx_ff   <= '0;
         w_ff     <= '0;
         pos_ff   <= '0;
         chg_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else if (cmd.eval) begin
         idx_ff <= idx_ff + 1'b1;
         if (id_op && match) begin
            found_ff <= 1'b1;
            fidx_ff  <= idx_ff[AW-1:0];
            fent_ff  <= rdata_ff;
         end
         if (op_ff == OP_COLLECT) begin
            if (live) w_ff <= w_ff + 1'b1;
            else      chg_ff <= 1'b1;
         end
         if (op_ff == OP_COMPACT && live) begin
            pos_ff <= pos_sat;
            if (rdata_ff.offset != pos_ff) chg_ff <= 1'b1;
         end
      end
   end

   // allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cursor_ff  <= '0;
         next_id_ff <= 32'd1;
         pool_ff    <= PoolReset;
      end else begin
         if (csr_valid) pool_ff <= csr_data;
         if (cmd.finish) begin
            if (op_ff == OP_CREATE && !oom && !full) begin
               count_ff   <= count_ff + 1'b1;
               cursor_ff  <= alloc_sum[SizeW-1:0];
               next_id_ff <= next_id_ff + 32'd1;
            end
            if (op_ff == OP_COLLECT) count_ff  <= w_ff;
            if (op_ff == OP_COMPACT) cursor_ff <= pos_ff;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         st_ff   <= ST_OK;
         oid_ff  <= '0;
         ooff_ff <= '0;
         olen_ff <= '0;
         oref_ff <= '0;
         ochg_ff <= 1'b0;
         case (op_ff)
            OP_CREATE: begin
               if (oom) begin
                  st_ff <= ST_NO_MEMORY;
               end else if (full) begin
                  st_ff <= ST_FULL;
               end else begin
                  oid_ff  <= next_id_ff;
                  ooff_ff <= cursor_ff;
                  olen_ff <= req_ff;
                  oref_ff <= 16'sd1;
               end
            end
            OP_SET, OP_GET, OP_INCREASE, OP_DECREASE: begin
               oid_ff <= id_ff;
               if (!found_ff) begin
                  st_ff <= ST_NOT_FOUND;
               end else if (op_ff == OP_SET && vlen_ff > fent_ff.size) begin
                  st_ff <= ST_TOO_LONG;
               end else begin
                  ooff_ff <= fent_ff.offset;
                  olen_ff <= fent_ff.size;
                  oref_ff <= new_refs;
               end
            end
            OP_COLLECT: begin
               ooff_ff <= cursor_ff;
               ochg_ff <= chg_ff;
            end
            OP_COMPACT: begin
               ooff_ff <= pos_ff;
               ochg_ff <= chg_ff;
            end
            default: st_ff <= ST_OK;
         endcase
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_status  = st_ff;
   assign out_id      = oid_ff;
   assign out_offset  = ooff_ff;
   assign out_length  = olen_ff;
   assign out_refs    = oref_ff;
   assign out_changed = ochg_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("table fill count beyond depth");
   a_write_behind: assert property (@(posedge clock) disable iff (reset)
      w_ff <= idx_ff)
      else $error("collect write index ahead of read index");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> out_valid_ff)
      else $error("result word not loaded after finish");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!out_valid_ff || out_ready))
      else $error("result word overwritten");
`endif

endmodule

/* sv/refcounted_block_allocator_top.sv */
// Sequence: each accepted word is latched; create and the unused op then go straight
// to commit; id ops walk the table until a hit at the k-th entry or the end of the table;
// collect and compact walk all N entries, N = table fill count (N <= MAX_BLOCKS).
// Throughput: one word at a time; the next word is taken once the result word loads;
// the walk reads each entry, then evaluates it; a stalled result word holds the commit.
// Reset: synchronous; table empty, next id 1, cursor 0, pool_size 10485760.
// ----------------------------------------------------------------------------
// refcounted_block_allocator_top
// Bump allocator over a byte pool with a reference-counted block table,
// collection of dead entries and compaction of live blocks.
// ----------------------------------------------------------------------------
module refcounted_block_allocator_top #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // block_id[31:0], request_size[56:32],
                                     // value_length[81:57], zero pad
   input  logic [2:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // status[2:0], result_id[34:3],
                                     // block_offset[59:35], block_length[84:60],
                                     // ref_count[100:85], changed[101], zero pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [24:0]  csr_data     // pool_size
);
   import rcba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic [StW-1:0]   status;
   logic [IdW-1:0]   result_id;
   logic [SizeW-1:0] block_offset, block_length;
   logic signed [RefW-1:0] ref_count;
   logic             changed;

   // pool size register is always writable
   assign csr_ready = 1'b1;

   rcba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rcba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_op       (req_tuser),
      .in_id       (req_tdata[31:0]),
      .in_req      (req_tdata[56:32]),
      .in_vlen     (req_tdata[81:57]),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (status),
      .out_id      (result_id),
      .out_offset  (block_offset),
      .out_length  (block_length),
      .out_refs    (ref_count),
      .out_changed (changed)
   );

   // result word packing, first field lowest
   assign rsp_tdata = {2'b00, changed, ref_count, block_length, block_offset,
                       result_id, status};

endmodule
